FILE: sv/etp_pkg.sv
// ----------------------------------------------------------------------------
// etp_pkg: shared types and constants
// Result status codes, fixed field widths and the divider status struct.
// ----------------------------------------------------------------------------
package etp_pkg;

	localparam int VAL_W  = 16;
	localparam int IDX_W  = 5;
	localparam int GRP_W  = 3;
	localparam int STAT_W = 3;

	localparam logic [STAT_W-1:0] ST_FOUND    = 3'd0;
	localparam logic [STAT_W-1:0] ST_COUNT    = 3'd1;
	localparam logic [STAT_W-1:0] ST_INDIV    = 3'd2;
	localparam logic [STAT_W-1:0] ST_NO_SPLIT = 3'd3;
	localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd4;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} etp_div_res_t;

endpackage

FILE: sv/etp_ram.sv
// ----------------------------------------------------------------------------
// etp_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module etp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/etp_div.sv
// ----------------------------------------------------------------------------
// etp_div: iterative signed divider
// Restoring division, one quotient bit per cycle; truncates toward zero.
// ----------------------------------------------------------------------------
module etp_div
	import etp_pkg::*;
#(
	parameter int W  = 21,
	parameter int DW = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] dividend,
	input  logic [DW-1:0]       divisor,
	output logic signed [W-1:0] quotient,
	output etp_div_res_t        res
);

	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [W-1:0]     quo_q;
	logic             neg_q;

	logic [DW:0] trial;
	logic        ge;

	assign trial = {rem_q, quo_q[W-1]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[W-1];
			quo_q <= dividend[W-1] ? W'(-dividend) : W'(dividend);
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? DW'(trial - {1'b0, divisor}) : DW'(trial);
		end
	end

	assign quotient     = neg_q ? -$signed(quo_q) : $signed(quo_q);
	assign res.done     = done_q;
	assign res.rem_zero = (rem_q == '0);

endmodule

FILE: sv/equal_sum_triplet_partition.sv
// Sequence: after the last value is loaded, a count check runs, then the
// divider, then a data-dependent backtracking search through the value
// RAM read port; each result is read back from the stack and value RAMs
// and held until the output accepts it.
// Throughput: one value per cycle while loading; input stalls otherwise.
// Reset: asynchronous active low, clears counters, used flags and state.
module equal_sum_triplet_partition
	import etp_pkg::*;
#(
	parameter int MAX_ITEMS = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    last,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [STAT_W-1:0]       status,
	output logic [GRP_W-1:0]        group,
	output logic [IDX_W-1:0]        idx_a,
	output logic [IDX_W-1:0]        idx_b,
	output logic [IDX_W-1:0]        idx_c,
	output logic signed [VAL_W-1:0] val_a,
	output logic signed [VAL_W-1:0] val_b,
	output logic signed [VAL_W-1:0] val_c,
	output logic                    final_res
);

	localparam int IW    = $clog2(MAX_ITEMS);
	localparam int CW    = $clog2(MAX_ITEMS + 1);
	localparam int SW    = VAL_W + CW;
	localparam int KMAX  = MAX_ITEMS / 3;
	localparam int KW    = $clog2(KMAX + 1);
	localparam int STK_D = (KMAX < 2) ? 2 : KMAX;
	localparam int SAW   = $clog2(STK_D);
	localparam int STK_W = 3 * IW + 2 * SW;

	typedef enum logic [4:0] {
		S_LOAD, S_CHECK, S_DIV, S_FIND_A, S_LD_A, S_NEXT_B, S_LD_B, S_NEXT_C,
		S_CMP_C, S_POP, S_POP_RD, S_E_RS, S_E_RA, S_E_RB, S_E_RC, S_E_RD, S_WAIT
	} state_t;

	typedef struct packed {
		logic [IW-1:0] a;
		logic [IW-1:0] b;
		logic [IW-1:0] c;
		logic [SW-1:0] psum;
		logic [SW-1:0] va;
	} stk_t;

	state_t                state_q;
	logic [CW-1:0]         cnt_q;
	logic [1:0]            mod3_q;
	logic [KW-1:0]         k_q;
	logic                  ovf_q;
	logic signed [SW-1:0]  sum_q;
	logic signed [SW-1:0]  target_q;
	logic signed [SW-1:0]  psum_q;
	logic signed [SW-1:0]  va_q;
	logic [KW-1:0]         lvl_q;
	logic [KW-1:0]         g_q;
	logic [CW-1:0]         a_q;
	logic [CW-1:0]         b_q;
	logic [CW-1:0]         c_q;
	logic [MAX_ITEMS-1:0]  used_q;
	logic [IW-1:0]         ia_q;
	logic [IW-1:0]         ib_q;
	logic [IW-1:0]         ic_q;

	logic                  in_acc;
	logic                  out_acc;
	logic                  v_we;
	logic [IW-1:0]         v_raddr;
	logic [VAL_W-1:0]      v_rdata;
	logic signed [SW-1:0]  v_ext;
	logic                  s_we;
	logic [SAW-1:0]        s_waddr;
	logic [SAW-1:0]        s_raddr;
	stk_t                  s_wdata;
	stk_t                  s_rdata;
	logic                  div_start;
	logic signed [SW-1:0]  div_q;
	etp_div_res_t          div_res;

	assign in_ready = (state_q == S_LOAD);
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;
	assign v_we     = in_acc && !ovf_q && (cnt_q < CW'(MAX_ITEMS));
	assign v_ext    = SW'($signed(v_rdata));
	assign div_start = (state_q == S_CHECK) && !ovf_q && (mod3_q == 2'd0);

	always_comb begin
		unique case (state_q)
			S_NEXT_B: v_raddr = b_q[IW-1:0];
			S_NEXT_C: v_raddr = c_q[IW-1:0];
			S_E_RA:   v_raddr = s_rdata.a;
			S_E_RB:   v_raddr = ib_q;
			S_E_RC:   v_raddr = ic_q;
			default:  v_raddr = a_q[IW-1:0];
		endcase
	end

	assign s_we          = (state_q == S_CMP_C) && (psum_q + v_ext == target_q);
	assign s_waddr       = SAW'(lvl_q - 1'b1);
	assign s_raddr       = (state_q == S_POP) ? SAW'(lvl_q) : SAW'(g_q);
	assign s_wdata.a     = a_q[IW-1:0];
	assign s_wdata.b     = b_q[IW-1:0];
	assign s_wdata.c     = c_q[IW-1:0];
	assign s_wdata.psum  = psum_q;
	assign s_wdata.va    = va_q;

	etp_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ITEMS)) u_vram (
		.clk   (clk),
		.we    (v_we),
		.waddr (cnt_q[IW-1:0]),
		.wdata (value),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	etp_ram #(.WIDTH(STK_W), .DEPTH(STK_D)) u_sram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	etp_div #(.W(SW), .DW(KW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (k_q),
		.quotient (div_q),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			cnt_q     <= '0;
			mod3_q    <= '0;
			k_q       <= '0;
			ovf_q     <= 1'b0;
			sum_q     <= '0;
			used_q    <= '0;
			out_valid <= 1'b0;
			lvl_q     <= '0;
			g_q       <= '0;
			a_q       <= '0;
			b_q       <= '0;
			c_q       <= '0;
			target_q  <= '0;
			psum_q    <= '0;
			va_q      <= '0;
			ia_q      <= '0;
			ib_q      <= '0;
			ic_q      <= '0;
			status    <= '0;
			group     <= '0;
			idx_a     <= '0;
			idx_b     <= '0;
			idx_c     <= '0;
			val_a     <= '0;
			val_b     <= '0;
			val_c     <= '0;
			final_res <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (!ovf_q) begin
							if (cnt_q < CW'(MAX_ITEMS)) begin
								sum_q <= sum_q + SW'(value);
								cnt_q <= cnt_q + 1'b1;
								if (mod3_q == 2'd2) begin
									mod3_q <= 2'd0;
									k_q    <= k_q + 1'b1;
								end else begin
									mod3_q <= mod3_q + 1'b1;
								end
							end else begin
								ovf_q <= 1'b1;
							end
						end
						if (last) begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (ovf_q || mod3_q != 2'd0) begin
						status    <= ovf_q ? ST_OVERFLOW : ST_COUNT;
						group     <= '0;
						idx_a     <= '0;
						idx_b     <= '0;
						idx_c     <= '0;
						val_a     <= '0;
						val_b     <= '0;
						val_c     <= '0;
						final_res <= 1'b1;
						out_valid <= 1'b1;
						state_q   <= S_WAIT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_res.done) begin
						if (!div_res.rem_zero) begin
							status    <= ST_INDIV;
							group     <= '0;
							idx_a     <= '0;
							idx_b     <= '0;
							idx_c     <= '0;
							val_a     <= '0;
							val_b     <= '0;
							val_c     <= '0;
							final_res <= 1'b1;
							out_valid <= 1'b1;
							state_q   <= S_WAIT;
						end else begin
							target_q <= div_q;
							lvl_q    <= k_q;
							a_q      <= '0;
							state_q  <= S_FIND_A;
						end
					end
				end
				S_FIND_A: begin
					if (a_q >= cnt_q) begin
						state_q <= S_POP;
					end else if (used_q[a_q[IW-1:0]]) begin
						a_q <= a_q + 1'b1;
					end else begin
						used_q[a_q[IW-1:0]] <= 1'b1;
						state_q <= S_LD_A;
					end
				end
				S_LD_A: begin
					va_q    <= v_ext;
					b_q     <= a_q + 1'b1;
					state_q <= S_NEXT_B;
				end
				S_NEXT_B: begin
					if (b_q >= cnt_q) begin
						used_q[a_q[IW-1:0]] <= 1'b0;
						state_q <= S_POP;
					end else if (used_q[b_q[IW-1:0]]) begin
						b_q <= b_q + 1'b1;
					end else begin
						used_q[b_q[IW-1:0]] <= 1'b1;
						state_q <= S_LD_B;
					end
				end
				S_LD_B: begin
					psum_q  <= va_q + v_ext;
					c_q     <= b_q + 1'b1;
					state_q <= S_NEXT_C;
				end
				S_NEXT_C: begin
					if (c_q >= cnt_q) begin
						used_q[b_q[IW-1:0]] <= 1'b0;
						b_q     <= b_q + 1'b1;
						state_q <= S_NEXT_B;
					end else if (used_q[c_q[IW-1:0]]) begin
						c_q <= c_q + 1'b1;
					end else begin
						state_q <= S_CMP_C;
					end
				end
				S_CMP_C: begin
					if (s_we) begin
						used_q[c_q[IW-1:0]] <= 1'b1;
						if (lvl_q == KW'(1)) begin
							g_q     <= '0;
							state_q <= S_E_RS;
						end else begin
							lvl_q   <= lvl_q - 1'b1;
							a_q     <= '0;
							state_q <= S_FIND_A;
						end
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= S_NEXT_C;
					end
				end
				S_POP: begin
					// level exhausted: no split at the top level, else back to the parent's saved triplet
					if (lvl_q == k_q) begin
						status    <= ST_NO_SPLIT;
						group     <= '0;
						idx_a     <= '0;
						idx_b     <= '0;
						idx_c     <= '0;
						val_a     <= '0;
						val_b     <= '0;
						val_c     <= '0;
						final_res <= 1'b1;
						out_valid <= 1'b1;
						state_q   <= S_WAIT;
					end else begin
						lvl_q   <= lvl_q + 1'b1;
						state_q <= S_POP_RD;
					end
				end
				S_POP_RD: begin
					a_q    <= CW'(s_rdata.a);
					b_q    <= CW'(s_rdata.b);
					c_q    <= CW'(s_rdata.c) + 1'b1;
					psum_q <= s_rdata.psum;
					va_q   <= s_rdata.va;
					used_q[s_rdata.c] <= 1'b0;
					state_q <= S_NEXT_C;
				end
				S_E_RS: begin
					state_q <= S_E_RA;
				end
				S_E_RA: begin
					ia_q    <= s_rdata.a;
					ib_q    <= s_rdata.b;
					ic_q    <= s_rdata.c;
					state_q <= S_E_RB;
				end
				S_E_RB: begin
					val_a   <= v_rdata;
					state_q <= S_E_RC;
				end
				S_E_RC: begin
					val_b   <= v_rdata;
					state_q <= S_E_RD;
				end
				S_E_RD: begin
					val_c     <= v_rdata;
					status    <= ST_FOUND;
					group     <= GRP_W'(g_q);
					idx_a     <= IDX_W'(ia_q);
					idx_b     <= IDX_W'(ib_q);
					idx_c     <= IDX_W'(ic_q);
					final_res <= (g_q + 1'b1 == k_q);
					out_valid <= 1'b1;
					state_q   <= S_WAIT;
				end
				S_WAIT: begin
					if (out_acc) begin
						out_valid <= 1'b0;
						if (!final_res) begin
							g_q     <= g_q + 1'b1;
							state_q <= S_E_RS;
						end else begin
							cnt_q   <= '0;
							mod3_q  <= '0;
							k_q     <= '0;
							ovf_q   <= 1'b0;
							sum_q   <= '0;
							used_q  <= '0;
							state_q <= S_LOAD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted while a result is pending");

	a_fail_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_FOUND) |-> final_res)
		else $error("failure result not marked final");

	a_found_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FOUND) |-> (idx_a < idx_b && idx_b < idx_c))
		else $error("triplet members out of order");

endmodule
